// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the point thinning block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define PT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also holds across reset
`define PT_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/ptthin_pkg.sv =====
// ----------------------------------------------------------------------------
// ptthin_pkg
// Types and constants shared by the polyline point thinning modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ptthin_pkg;

   // span store depth default
   localparam int SPAN_DEPTH_DEF = 64;

   // command queue depth between front and back
   localparam int QUEUE_DEPTH = 4;

   // register indexes of the csr port
   localparam logic [1:0] CSR_TOLERANCE    = 2'd0;
   localparam logic [1:0] CSR_CONSERVATIVE = 2'd1;
   localparam logic [1:0] CSR_USE_GROUPS   = 2'd2;

   typedef struct packed {
      logic signed [31:0] x_coord;
      logic signed [31:0] y_coord;
      logic [31:0]        group_id;
      logic               locked;
      logic               is_break;
      logic               last_point;
   } req_data_type;

   typedef struct packed {
      logic keep;
      logic last_result;
   } rsp_data_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
   } point_type;

   typedef struct packed {
      logic [30:0] tolerance;
      logic        conservative;
      logic        use_groups;
   } cfg_type;

   // one unit of work for the back end
   typedef struct packed {
      point_type p;          // point under decision
      point_type b;          // reference point of the test line
      logic      test;       // run the distance test
      logic      keep_fix;   // keep value when no test runs
      logic      anchor_set; // make p the anchor (no test)
      logic      span_clear; // empty the span store afterwards
      logic      force_keep; // part of two points ends here
      logic      has_rsp;    // a result beat goes out
      logic      last;       // result is the final one of the polyline
   } cmd_type;

endpackage

`default_nettype wire

// ===== sv/ptthin_queue.sv =====
// ----------------------------------------------------------------------------
// ptthin_queue
// Small command queue between the classifying front and the test back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ptthin_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire ptthin_pkg::cmd_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output ptthin_pkg::cmd_type     pop_data,
   output logic                    not_empty
);
   localparam int QD = ptthin_pkg::QUEUE_DEPTH;
   localparam int QW = $clog2(QD);

   ptthin_pkg::cmd_type entry_ff [QD];
   logic [QW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == (QW+1)'(QD));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QW'(QD-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QW'(QD-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ptthin_front.sv =====
// ----------------------------------------------------------------------------
// ptthin_front
// Accepts input beats, tracks parts and polylines, and turns each beat into
// up to three commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ptthin_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    use_groups,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire ptthin_pkg::req_data_type req_data,
   output logic                         q_push,
   output ptthin_pkg::cmd_type          q_data,
   input  wire logic                    q_full
);
   // part and polyline tracking
   logic [1:0]            pcount_ff, pcount_in;
   logic [1:0]            plen_ff, plen_in;
   logic                  popen_ff, popen_in;
   ptthin_pkg::point_type pstart_ff, pstart_in;
   ptthin_pkg::point_type pend_pt_ff;
   logic [31:0]           pend_grp_ff;
   logic                  pend_lock_ff, pend_brk_ff, pend_first_ff;

   // command buffer for the beat in hand
   ptthin_pkg::cmd_type   cbuf_ff [3];
   ptthin_pkg::cmd_type   c0, c1, c2;
   logic [2:0]            mask_ff, mask_in, mask_new;

   ptthin_pkg::point_type cur;
   logic                  accept, grp_chg, part_end0, new_part;
   logic [1:0]            pc_sat;

   assign req_stall = |mask_ff;
   assign accept    = req_valid && !req_stall;

   // classify the beat and build its commands
   always_comb begin
      cur       = '{x: req_data.x_coord, y: req_data.y_coord};
      grp_chg   = use_groups && (req_data.group_id != pend_grp_ff);
      part_end0 = req_data.is_break || grp_chg;
      new_part  = !req_data.is_break && (!popen_ff || grp_chg);

      // decision for the pending point
      c0         = '0;
      c0.has_rsp = 1'b1;
      c0.p       = pend_pt_ff;
      if (pend_brk_ff) begin
         c0.keep_fix = 1'b1;
      end else if (pend_first_ff || pend_lock_ff) begin
         c0.keep_fix   = 1'b1;
         c0.anchor_set = 1'b1;
      end else begin
         c0.test       = 1'b1;
         c0.b          = part_end0 ? pstart_ff : cur;
         c0.force_keep = part_end0 && (plen_ff == 2'd2);
      end

      // new part starts at this point
      c1            = '0;
      c1.p          = cur;
      c1.anchor_set = 1'b1;

      // part state after this beat
      popen_in  = popen_ff;
      pstart_in = pstart_ff;
      plen_in   = plen_ff;
      if (req_data.is_break) begin
         popen_in = 1'b0;
      end else if (new_part) begin
         popen_in  = 1'b1;
         pstart_in = cur;
         plen_in   = 2'd1;
      end else if (plen_ff != 2'd3) begin
         plen_in = plen_ff + 1'b1;
      end
      pc_sat = (pcount_ff == 2'd3) ? 2'd3 : pcount_ff + 1'b1;

      // decision for the final point itself
      c2            = '0;
      c2.has_rsp    = 1'b1;
      c2.last       = 1'b1;
      c2.span_clear = 1'b1;
      c2.p          = cur;
      if (req_data.is_break) begin
         c2.keep_fix = 1'b1;
      end else if (new_part || req_data.locked) begin
         c2.keep_fix   = 1'b1;
         c2.anchor_set = 1'b1;
      end else if (pc_sat != 2'd3) begin
         c2.keep_fix = 1'b1;
      end else begin
         c2.test       = 1'b1;
         c2.b          = pstart_in;
         c2.force_keep = (plen_in == 2'd2);
      end

      mask_new  = {req_data.last_point, new_part, (pcount_ff != 2'd0)};
      pcount_in = req_data.last_point ? 2'd0 : pc_sat;
   end

   // drain the buffer one command per cycle while the queue is not full, oldest first
   always_comb begin
      q_push  = |mask_ff && !q_full;
      mask_in = mask_ff;
      if (mask_ff[0]) begin
         q_data = cbuf_ff[0];
      end else if (mask_ff[1]) begin
         q_data = cbuf_ff[1];
      end else begin
         q_data = cbuf_ff[2];
      end
      if (q_push) begin
         if (mask_ff[0]) begin
            mask_in[0] = 1'b0;
         end else if (mask_ff[1]) begin
            mask_in[1] = 1'b0;
         end else begin
            mask_in[2] = 1'b0;
         end
      end
      if (accept) begin
         mask_in = mask_new;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff       <= '0;
         pcount_ff     <= '0;
         plen_ff       <= '0;
         popen_ff      <= 1'b0;
         pend_lock_ff  <= 1'b0;
         pend_brk_ff   <= 1'b0;
         pend_first_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         if (accept) begin
            pcount_ff     <= pcount_in;
            plen_ff       <= req_data.last_point ? 2'd0 : plen_in;
            popen_ff      <= req_data.last_point ? 1'b0 : popen_in;
            pend_lock_ff  <= req_data.locked;
            pend_brk_ff   <= req_data.is_break;
            pend_first_ff <= new_part;
         end
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      if (accept) begin
         cbuf_ff[0]  <= c0;
         cbuf_ff[1]  <= c1;
         cbuf_ff[2]  <= c2;
         pend_pt_ff  <= cur;
         pend_grp_ff <= req_data.group_id;
         pstart_ff   <= pstart_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ptthin_back.sv =====
// ----------------------------------------------------------------------------
// ptthin_back
// Runs the distance test of each test command on one shared 32x32 multiplier,
// keeps the anchor and the span store, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptthin_back #(
   parameter int SPAN_DEPTH = ptthin_pkg::SPAN_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ptthin_pkg::cfg_type cfg,
   input  wire logic                q_valid,
   output logic                     q_pop,
   input  wire ptthin_pkg::cmd_type q_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output ptthin_pkg::rsp_data_type rsp_data
);
   localparam int CW = $clog2(SPAN_DEPTH + 2);
   localparam int IW = $clog2(SPAN_DEPTH);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b00_0000_0001,
      ST_BB   = 10'b00_0000_0010,
      ST_TOL  = 10'b00_0000_0100,
      ST_THR  = 10'b00_0000_1000,
      ST_DOT  = 10'b00_0001_0000,
      ST_CRS  = 10'b00_0010_0000,
      ST_SQR  = 10'b00_0100_0000,
      ST_READ = 10'b00_1000_0000,
      ST_LOAD = 10'b01_0000_0000,
      ST_FIN  = 10'b10_0000_0000
   } bk_state_type;

   bk_state_type          state_ff, state_in;
   logic [3:0]            step_ff, step_in;
   ptthin_pkg::cmd_type   cmd_ff;
   ptthin_pkg::point_type anchor_ff;
   ptthin_pkg::point_type span_mem [SPAN_DEPTH];
   ptthin_pkg::point_type span_q_ff;
   logic [CW-1:0]         span_cnt_ff;
   logic [IW-1:0]         span_idx_ff;

   // operand magnitudes and signs
   logic [31:0]  axm_ff, aym_ff, bxm_ff, bym_ff;
   logic         axn_ff, ayn_ff, bxn_ff, byn_ff;
   logic         b_zero_ff, a_nz_ff, is_p_ff;

   // multiplier stage and accumulators
   logic [63:0]  mul_ff;
   logic         mul_vld_ff, mul_neg_ff;
   logic [2:0]   mul_sh_ff;
   logic [191:0] uacc_ff;
   logic [66:0]  sacc_ff;

   // phase results
   logic [64:0]  bb_ff, cm_ff;
   logic [61:0]  tol2_ff;
   logic [127:0] thr_ff;
   logic         pos_ff, keep_ff, move_ff;

   logic                     rsp_valid_ff;
   ptthin_pkg::rsp_data_type rsp_data_ff;

   logic [31:0] op_a, op_b;
   logic [2:0]  op_sh;
   logic        op_neg, op_go, cap, far, out_free;
   logic [3:0]  n_steps, lj_w;
   logic [1:0]  li, lj;
   logic [32:0] dpx, dpy, dbx, dby, dqx, dqy;

   // signed difference v - a as sign and 32-bit magnitude
   function automatic logic [32:0] diff_sm(input logic [31:0] v, input logic [31:0] a);
      logic [32:0] d;
      logic [32:0] m;
      d = {v[31], v} - {a[31], a};
      m = d[32] ? (33'd0 - d) : d;
      return {d[32], m[31:0]};
   endfunction

   // 32-bit limb of a 65-bit value
   function automatic logic [31:0] limb3(input logic [64:0] v, input logic [1:0] k);
      case (k)
         2'd0:    return v[31:0];
         2'd1:    return v[63:32];
         default: return {31'd0, v[64]};
      endcase
   endfunction

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == ST_IDLE) && q_valid && out_free;
   assign far       = (uacc_ff >= {64'd0, thr_ff});

   assign dpx = diff_sm(q_data.p.x, anchor_ff.x);
   assign dpy = diff_sm(q_data.p.y, anchor_ff.y);
   assign dbx = diff_sm(q_data.b.x, anchor_ff.x);
   assign dby = diff_sm(q_data.b.y, anchor_ff.y);
   assign dqx = diff_sm(span_q_ff.x, anchor_ff.x);
   assign dqy = diff_sm(span_q_ff.y, anchor_ff.y);

   // limb pair of a step in a multi-limb product
   always_comb begin
      li   = (step_ff >= 4'd6) ? 2'd2 : ((step_ff >= 4'd3) ? 2'd1 : 2'd0);
      lj_w = step_ff - {1'b0, li, 1'b0} - {2'b0, li};
      lj   = lj_w[1:0];
   end

   // operand selection for the shared multiplier
   always_comb begin
      op_a    = '0;
      op_b    = '0;
      op_sh   = '0;
      op_neg  = 1'b0;
      n_steps = '0;
      case (state_ff)
         ST_BB: begin
            n_steps = 4'd2;
            op_a    = (step_ff == 4'd0) ? bxm_ff : bym_ff;
            op_b    = op_a;
         end
         ST_TOL: begin
            n_steps = 4'd1;
            op_a    = {1'b0, cfg.tolerance};
            op_b    = {1'b0, cfg.tolerance};
         end
         ST_THR: begin
            n_steps = 4'd6;
            op_a    = (li == 2'd0) ? tol2_ff[31:0] : {2'b0, tol2_ff[61:32]};
            op_b    = limb3(bb_ff, lj);
            op_sh   = {1'b0, li} + {1'b0, lj};
         end
         ST_DOT: begin
            n_steps = 4'd2;
            if (step_ff == 4'd0) begin
               op_a   = axm_ff;
               op_b   = bxm_ff;
               op_neg = axn_ff ^ bxn_ff;
            end else begin
               op_a   = aym_ff;
               op_b   = bym_ff;
               op_neg = ayn_ff ^ byn_ff;
            end
         end
         ST_CRS: begin
            n_steps = 4'd2;
            if (step_ff == 4'd0) begin
               op_a   = axm_ff;
               op_b   = bym_ff;
               op_neg = axn_ff ^ byn_ff;
            end else begin
               op_a   = aym_ff;
               op_b   = bxm_ff;
               op_neg = !(ayn_ff ^ bxn_ff);
            end
         end
         ST_SQR: begin
            n_steps = 4'd9;
            op_a    = limb3(cm_ff, li);
            op_b    = limb3(cm_ff, lj);
            op_sh   = {1'b0, li} + {1'b0, lj};
         end
         default: begin
            n_steps = '0;
         end
      endcase
      op_go = (step_ff < n_steps);
      cap   = (n_steps != 4'd0) && (step_ff == n_steps + 4'd1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = cap ? 4'd0 : step_ff + 4'd1;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (q_pop && q_data.test) begin
               state_in = ST_BB;
            end
         end
         ST_BB: begin
            if (cap) state_in = ST_TOL;
         end
         ST_TOL: begin
            if (cap) state_in = ST_THR;
         end
         ST_THR: begin
            if (cap) state_in = ST_DOT;
         end
         ST_DOT: begin
            if (cap) state_in = ST_CRS;
         end
         ST_CRS: begin
            if (cap) state_in = ST_SQR;
         end
         ST_SQR: begin
            if (cap) begin
               state_in = ST_FIN;
               if (is_p_ff) begin
                  if (!(far && pos_ff) && pos_ff && cfg.conservative &&
                      span_cnt_ff <= CW'(SPAN_DEPTH) && span_cnt_ff != '0) begin
                     state_in = ST_READ;
                  end
               end else if (!(far && pos_ff) &&
                            (CW'(span_idx_ff) + CW'(1) < span_cnt_ff)) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            step_in  = '0;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            step_in  = '0;
            state_in = ST_DOT;
         end
         ST_FIN: begin
            step_in = '0;
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            step_in  = '0;
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         step_ff    <= '0;
         mul_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         step_ff    <= step_in;
         mul_vld_ff <= op_go;
      end
   end

   // shared multiplier, one product per cycle
   always_ff @(posedge clock) begin
      mul_ff     <= op_a * op_b;
      mul_sh_ff  <= op_sh;
      mul_neg_ff <= op_neg;
   end

   // accumulators, cleared between phases
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE || state_ff == ST_LOAD || cap) begin
         uacc_ff <= '0;
         sacc_ff <= '0;
      end else if (mul_vld_ff) begin
         if (state_ff == ST_DOT || state_ff == ST_CRS) begin
            sacc_ff <= mul_neg_ff ? sacc_ff - {3'd0, mul_ff} : sacc_ff + {3'd0, mul_ff};
         end else begin
            case (mul_sh_ff)
               3'd0:    uacc_ff <= uacc_ff + {128'd0, mul_ff};
               3'd1:    uacc_ff <= uacc_ff + {96'd0, mul_ff, 32'd0};
               3'd2:    uacc_ff <= uacc_ff + {64'd0, mul_ff, 64'd0};
               3'd3:    uacc_ff <= uacc_ff + {32'd0, mul_ff, 96'd0};
               default: uacc_ff <= uacc_ff + {mul_ff, 128'd0};
            endcase
         end
      end
   end

   // phase results, operands and decision
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff    <= q_data;
         is_p_ff   <= 1'b1;
         keep_ff   <= 1'b0;
         move_ff   <= 1'b0;
         axn_ff    <= dpx[32];
         axm_ff    <= dpx[31:0];
         ayn_ff    <= dpy[32];
         aym_ff    <= dpy[31:0];
         bxn_ff    <= dbx[32];
         bxm_ff    <= dbx[31:0];
         byn_ff    <= dby[32];
         bym_ff    <= dby[31:0];
         b_zero_ff <= (dbx[31:0] == '0) && (dby[31:0] == '0);
         a_nz_ff   <= (dpx[31:0] != '0) || (dpy[31:0] != '0);
      end
      if (state_ff == ST_LOAD) begin
         axn_ff <= dqx[32];
         axm_ff <= dqx[31:0];
         ayn_ff <= dqy[32];
         aym_ff <= dqy[31:0];
      end
      if (cap) begin
         case (state_ff)
            ST_BB:  bb_ff   <= uacc_ff[64:0];
            ST_TOL: tol2_ff <= uacc_ff[61:0];
            ST_THR: thr_ff  <= uacc_ff[127:0];
            ST_DOT: pos_ff  <= !sacc_ff[66] && (sacc_ff != '0);
            ST_CRS: cm_ff   <= sacc_ff[66] ? 65'(67'd0 - sacc_ff) : sacc_ff[64:0];
            ST_SQR: begin
               if (far && pos_ff) begin
                  keep_ff <= 1'b1;
                  move_ff <= 1'b1;
               end else if (is_p_ff) begin
                  if (pos_ff) begin
                     // overflowed span store keeps the point
                     if (cfg.conservative && span_cnt_ff > CW'(SPAN_DEPTH)) begin
                        keep_ff <= 1'b1;
                        move_ff <= 1'b1;
                     end
                     is_p_ff     <= 1'b0;
                     span_idx_ff <= '0;
                  end else begin
                     // reference point sits on the anchor
                     keep_ff <= b_zero_ff && a_nz_ff;
                  end
               end else begin
                  span_idx_ff <= span_idx_ff + 1'b1;
               end
            end
            default: begin
               pos_ff <= pos_ff;
            end
         endcase
      end
   end

   // span store read, registered
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         span_q_ff <= span_mem[span_idx_ff];
      end
      if (state_ff == ST_FIN && out_free && !move_ff && span_cnt_ff < CW'(SPAN_DEPTH)) begin
         span_mem[span_cnt_ff[IW-1:0]] <= cmd_ff.p;
      end
   end

   // anchor, span fill count and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         span_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (q_pop && !q_data.test) begin
            if (q_data.anchor_set) begin
               anchor_ff   <= q_data.p;
               span_cnt_ff <= '0;
            end
            if (q_data.span_clear) begin
               span_cnt_ff <= '0;
            end
            if (q_data.has_rsp) begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= '{keep: q_data.keep_fix, last_result: q_data.last};
            end
         end
         if (state_ff == ST_FIN && out_free) begin
            if (move_ff) begin
               anchor_ff   <= cmd_ff.p;
               span_cnt_ff <= '0;
            end else if (span_cnt_ff < CW'(SPAN_DEPTH)) begin
               span_cnt_ff <= span_cnt_ff + 1'b1;
            end else begin
               span_cnt_ff <= CW'(SPAN_DEPTH + 1);
            end
            if (cmd_ff.span_clear) begin
               span_cnt_ff <= '0;
            end
            if (cmd_ff.has_rsp) begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= '{keep: keep_ff || cmd_ff.force_keep, last_result: cmd_ff.last};
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/polyline_point_thinning.sv =====
// A point that needs the distance test runs the BB, TOL, THR, DOT, CRS and
// SQR phases, and each span point rechecked in conservative mode adds a READ,
// LOAD, DOT, CRS and SQR pass; breaks, part starts, locked points and short
// polylines skip the test. The single shared 32x32 multiplier works out
// |b|^2, tolerance^2, the threshold, the dot and cross products and the
// squared cross product one partial product a cycle. The front turns each
// input beat into up to three commands, one per cycle while the queue is not
// full, and a four-entry queue lets it run ahead of the back end. Results
// come one beat late; the last_point beat also returns its own result. The
// span store is not cleared after reset; its fill count guards every read.
// ----------------------------------------------------------------------------
// polyline_point_thinning
// Streaming polyline thinning by perpendicular distance, top level.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_point_thinning #(
   parameter int SPAN_DEPTH = ptthin_pkg::SPAN_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire ptthin_pkg::req_data_type req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output ptthin_pkg::rsp_data_type      rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [1:0]               csr_index,
   input  wire logic [31:0]              csr_wdata
);
   ptthin_pkg::cfg_type cfg_ff;
   ptthin_pkg::cmd_type q_in_data, q_out_data;
   logic                q_push, q_full, q_pop, q_valid;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ptthin_pkg::CSR_TOLERANCE:    cfg_ff.tolerance    <= csr_wdata[30:0];
            ptthin_pkg::CSR_CONSERVATIVE: cfg_ff.conservative <= csr_wdata[0];
            ptthin_pkg::CSR_USE_GROUPS:   cfg_ff.use_groups   <= csr_wdata[0];
            default:                      cfg_ff              <= cfg_ff;
         endcase
      end
   end

   ptthin_front u_front (
      .clock      (clock),
      .reset      (reset),
      .use_groups (cfg_ff.use_groups),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .q_push     (q_push),
      .q_data     (q_in_data),
      .q_full     (q_full)
   );

   ptthin_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .not_empty (q_valid)
   );

   ptthin_back #(
      .SPAN_DEPTH (SPAN_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_data    (q_out_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sv/ptthin_checker.sv =====
// ----------------------------------------------------------------------------
// ptthin_checker
// Port-level checks of the point thinning block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ptthin_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire ptthin_pkg::rsp_data_type rsp_data
);
   // a stalled result beat holds
   `PT_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "result beat dropped under stall")

   // reset empties the result register
   `PT_ASSERT_RST(a_rst_rsp, reset |=> !rsp_valid, "result valid after reset")

   // reset empties the front command buffer
   `PT_ASSERT_RST(a_rst_req, reset |=> !req_stall, "input stalled after reset")

endmodule

bind polyline_point_thinning ptthin_checker u_ptthin_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== dv/ptthin_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptthin_tb_checker
// Watches the request, result and csr channels of the point thinning block,
// predicts the keep flag of every point and compares each result beat with
// the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module ptthin_tb_checker #(
   parameter int SPAN_DEPTH = ptthin_pkg::SPAN_DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_stall,
   input  wire ptthin_pkg::req_data_type req_data,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   input  wire ptthin_pkg::rsp_data_type rsp_data,
   input  wire logic                     csr_valid,
   input  wire logic                     csr_ready,
   input  wire logic [1:0]               csr_index,
   input  wire logic [31:0]              csr_wdata,
   output int                            fail_count,
   output int                            keep_pending
);

   typedef struct {
      longint x;
      longint y;
   } xy_type;

   // predicted configuration
   logic [30:0] tol_q;
   logic        cons_q;
   logic        groups_q;

   // predicted block state
   xy_type      anchor_q, start_q, held_pt_q;
   bit          held_lock_q, held_brk_q, held_first_q;
   logic [31:0] held_group_q;
   xy_type      span_q [SPAN_DEPTH];
   int          span_cnt_q, pt_cnt_q, part_len_q;
   bit          part_open_q;

   // expected result beats, oldest first
   ptthin_pkg::rsp_data_type keep_queue [$];

   task automatic report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   // distance test of a against line b; pos tells a.b > 0
   function automatic bit far_enough(longint ax, longint ay, longint bx, longint by,
                                     logic [159:0] thr, output bit pos);
      logic signed [135:0] eax, eay, ebx, eby, dot, crs;
      logic [159:0]        m;
      eax = ax;
      eay = ay;
      ebx = bx;
      eby = by;
      dot = eax * ebx + eay * eby;
      crs = eax * eby - eay * ebx;
      pos = dot > 0;
      m = crs < 0 ? -crs : crs;
      return (m * m) >= thr;
   endfunction

   function automatic void move_anchor(xy_type p);
      anchor_q = p;
      span_cnt_q = 0;
   endfunction

   // keep decision for the held point
   function automatic bit decide_keep(bit ends, bit nbrk, logic [31:0] ngrp, xy_type np);
      xy_type              p, b;
      bit                  keep, move, pos, qp, part_end;
      longint              ax, ay, bx, by;
      logic signed [135:0] ebx, eby;
      logic [159:0]        bb, tt, thr;
      p = held_pt_q;
      keep = 0;
      move = 0;
      if (held_brk_q) return 1;
      if (held_first_q || held_lock_q) begin
         move_anchor(p);
         return 1;
      end
      if (ends && pt_cnt_q < 3) return 1;
      part_end = ends || nbrk || (groups_q && ngrp != held_group_q);
      b = part_end ? start_q : np;
      ax = p.x - anchor_q.x;
      ay = p.y - anchor_q.y;
      bx = b.x - anchor_q.x;
      by = b.y - anchor_q.y;
      ebx = bx;
      eby = by;
      bb = ebx * ebx + eby * eby;
      tt = tol_q;
      thr = tt * tt * bb;
      if (far_enough(ax, ay, bx, by, thr, pos) && pos) begin
         keep = 1;
         move = 1;
      end else if (pos) begin
         if (cons_q && span_cnt_q > SPAN_DEPTH) begin
            keep = 1;
            move = 1;
         end else if (cons_q) begin
            // recheck the points dropped since the anchor
            for (int j = 0; j < span_cnt_q && j < SPAN_DEPTH; j++) begin
               if (far_enough(span_q[j].x - anchor_q.x, span_q[j].y - anchor_q.y,
                              bx, by, thr, qp) && qp) begin
                  keep = 1;
                  move = 1;
                  break;
               end
            end
         end
      end else if (bx == 0 && by == 0 && (ax != 0 || ay != 0)) begin
         // line folds back onto the anchor
         keep = 1;
      end
      if (part_end && part_len_q == 2) keep = 1;
      if (move) move_anchor(p);
      else if (span_cnt_q < SPAN_DEPTH) span_q[span_cnt_q++] = p;
      else span_cnt_q = SPAN_DEPTH + 1;
      return keep;
   endfunction

   // expected beats caused by one accepted point
   function automatic void predict_point(ptthin_pkg::req_data_type d);
      xy_type                   cur;
      ptthin_pkg::rsp_data_type r;
      cur.x = longint'(d.x_coord);
      cur.y = longint'(d.y_coord);
      if (pt_cnt_q > 0) begin
         r.keep = decide_keep(0, d.is_break, d.group_id, cur);
         r.last_result = 0;
         keep_queue.push_back(r);
      end
      held_lock_q = d.locked;
      held_brk_q = 0;
      held_first_q = 0;
      if (d.is_break) begin
         held_brk_q = 1;
         part_open_q = 0;
      end else if (!part_open_q || (groups_q && d.group_id != held_group_q)) begin
         held_first_q = 1;
         move_anchor(cur);
         start_q = cur;
         part_len_q = 1;
         part_open_q = 1;
      end else if (part_len_q < 3) begin
         part_len_q++;
      end
      held_pt_q = cur;
      held_group_q = d.group_id;
      if (pt_cnt_q < 3) pt_cnt_q++;
      if (d.last_point) begin
         r.keep = decide_keep(1, 0, d.group_id, cur);
         r.last_result = 1;
         keep_queue.push_back(r);
         pt_cnt_q = 0;
         part_len_q = 0;
         span_cnt_q = 0;
         part_open_q = 0;
      end
   endfunction

   // channel monitor
   always @(posedge clock) begin
      ptthin_pkg::rsp_data_type e;
      if (reset) begin
         tol_q = '0;
         cons_q = 0;
         groups_q = 0;
         anchor_q = '{0, 0};
         start_q = '{0, 0};
         held_pt_q = '{0, 0};
         held_lock_q = 0;
         held_brk_q = 0;
         held_first_q = 0;
         held_group_q = '0;
         span_cnt_q = 0;
         pt_cnt_q = 0;
         part_len_q = 0;
         part_open_q = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ptthin_pkg::CSR_TOLERANCE:    tol_q = csr_wdata[30:0];
               ptthin_pkg::CSR_CONSERVATIVE: cons_q = csr_wdata[0];
               ptthin_pkg::CSR_USE_GROUPS:   groups_q = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (keep_queue.size() == 0) begin
               report("result beat with nothing expected");
            end else begin
               e = keep_queue.pop_front();
               if (rsp_data.keep !== e.keep)
                  report($sformatf("keep %b, expected %b", rsp_data.keep, e.keep));
               if (rsp_data.last_result !== e.last_result)
                  report($sformatf("last_result %b, expected %b",
                                   rsp_data.last_result, e.last_result));
            end
         end
         if (req_valid && !req_stall) predict_point(req_data);
      end
      keep_pending = keep_queue.size();
   end

   initial begin
      fail_count = 0;
      keep_pending = 0;
   end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the polyline point thinning block: directed polylines, then
// random polylines under several tolerance and mode settings, with bursty
// request traffic and a stalling result side; a checker predicts every beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

   localparam int PHASE_ITEMS = 140;
   localparam int DRAIN_CYCLES = 2000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   ptthin_pkg::req_data_type req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   ptthin_pkg::rsp_data_type rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [1:0]               csr_index;
   logic [31:0]              csr_wdata;

   int fail_count, keep_pending;
   int burst_left;
   bit hold_go;
   int cx, cy;
   logic [31:0] cur_group;

   polyline_point_thinning u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   ptthin_tb_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .keep_pending(keep_pending)
   );

   // clock
   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #200_000_000;
      $display("Verification failed");
      $finish;
   end

   // result side stall pattern, with one long hold-off on request
   initial begin
      int mode, left, hold;
      bit held;
      rsp_stall = 0;
      mode = 0;
      left = 0;
      hold = 0;
      held = 0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 300);
         end
         left--;
         if (hold_go && !held) begin
            held = 1;
            hold = 3000;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1;
         end else begin
            case (mode)
               0: rsp_stall <= 0;
               1: rsp_stall <= ($urandom_range(0, 2) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (left % 5 < 2);
            endcase
         end
      end
   end

   function automatic ptthin_pkg::req_data_type mk(logic [31:0] x, logic [31:0] y,
                                                   logic [31:0] g, bit lk, bit br,
                                                   bit last);
      ptthin_pkg::req_data_type d;
      d.x_coord = x;
      d.y_coord = y;
      d.group_id = g;
      d.locked = lk;
      d.is_break = br;
      d.last_point = last;
      return d;
   endfunction

   // one request beat, in bursts with random gaps
   task automatic send_point(ptthin_pkg::req_data_type d);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1;
      req_data <= d;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(negedge clock);
      req_valid <= 0;
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic set_mode(logic [30:0] tol, bit cons, bit grp);
      csr_write(ptthin_pkg::CSR_TOLERANCE, {1'($urandom_range(0, 1)), tol});
      csr_write(ptthin_pkg::CSR_CONSERVATIVE, {31'($urandom), cons});
      csr_write(ptthin_pkg::CSR_USE_GROUPS, {31'($urandom), grp});
   endtask

   // wait until every expected beat is back, then let the back end settle
   task automatic drain;
      @(negedge clock);
      req_valid <= 0;
      while (keep_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // random polyline: a walk with random content, some noise items
   task automatic send_polyline(int len, int step);
      ptthin_pkg::req_data_type d;
      for (int i = 0; i < len; i++) begin
         cx += $signed($urandom_range(0, 2 * step)) - step;
         cy += $signed($urandom_range(0, 2 * step)) - step;
         if ($urandom_range(0, 7) == 0) cur_group = ($urandom_range(0, 3) == 0) ?
                                                     $urandom : $urandom_range(0, 3);
         d = mk(cx, cy, cur_group, $urandom_range(0, 11) == 0,
                $urandom_range(0, 11) == 0, i == len - 1);
         if ($urandom_range(0, 15) == 0) begin
            d.x_coord = $urandom;
            d.y_coord = $urandom;
         end
         if ($urandom_range(0, 40) == 0) d.last_point = 1;
         send_point(d);
      end
   endtask

   task automatic random_phase(int n_items, int step);
      int sent, len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 20);
         send_polyline(len, step);
         sent += len;
      end
   endtask

   // stimulus
   initial begin
      logic [31:0] mx, mn;
      mx = 32'h7fffffff;
      mn = 32'h80000000;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_valid = 0;
      csr_index = '0;
      csr_wdata = '0;
      hold_go = 0;
      burst_left = 0;
      cx = 0;
      cy = 0;
      cur_group = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed polylines
      set_mode(31'h0002_0000, 1, 1);
      send_point(mk(5, 5, 0, 0, 0, 1));
      send_point(mk(mx, mx, '1, 0, 0, 0));
      send_point(mk(mn, mn, '1, 0, 0, 1));
      send_point(mk(0, 0, 0, 0, 0, 0));
      send_point(mk(32'h50000, 32'h50000, 0, 0, 0, 0));
      send_point(mk(0, 0, 0, 0, 0, 0));
      send_point(mk(32'h70000, 0, 0, 0, 0, 1));
      send_point(mk(0, 0, 1, 0, 0, 0));
      send_point(mk(32'h10000, 32'h8000, 1, 1, 0, 0));
      send_point(mk(32'h20000, 0, 1, 0, 0, 0));
      send_point(mk(mn, mx, 1, 0, 1, 0));
      send_point(mk(0, 0, 1, 0, 0, 0));
      send_point(mk(32'h10000, 32'h100, 1, 0, 0, 0));
      send_point(mk(32'h20000, 0, 2, 0, 0, 0));
      send_point(mk(32'h30000, 32'h90000, 2, 0, 0, 0));
      send_point(mk(32'h40000, 0, 2, 0, 0, 0));
      send_point(mk(32'h50000, 32'h100, 2, 0, 0, 0));
      send_point(mk(32'h60000, 32'h40000, 2, 0, 0, 1));
      send_point(mk(mx, mn, 32'h0, 1, 0, 0));
      send_point(mk(mn, mx, 32'h0, 0, 0, 0));
      send_point(mk(mx, mx, 32'h0, 0, 0, 1));
      drain;

      // zero tolerance, plain mode, long hold-off on the result side
      set_mode(31'h0, 0, 0);
      hold_go = 1;
      random_phase(PHASE_ITEMS, 32'h20000);
      drain;

      // largest tolerance, conservative, groups; straight run overflows the span
      set_mode(31'h7fffffff, 1, 1);
      for (int i = 0; i < 70; i++)
         send_point(mk(i << 16, i, 7, 0, 0, i == 69));
      random_phase(PHASE_ITEMS - 70, 32'h20000);
      drain;

      // moderate tolerance, conservative
      set_mode(31'h0001_8000, 1, 0);
      random_phase(PHASE_ITEMS, 32'h30000);
      drain;

      // moderate tolerance, groups only
      set_mode(31'h0000_c000, 0, 1);
      random_phase(PHASE_ITEMS, 32'h30000);
      drain;

      // random settings
      set_mode(31'($urandom_range(0, 32'h80000)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
      random_phase(PHASE_ITEMS, 32'h40000);
      drain;

      if (fail_count == 0 && keep_pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
